// ===== hdl/ciatk_pkg.sv =====
`timescale 1ns / 1ps

package ciatk_pkg;

  localparam int KEY_COUNT   = 64;
  localparam int KEY_IDX_W   = $clog2(KEY_COUNT);
  localparam int WINDOW_SIZE = 16;
  localparam int WIN_IDX_W   = $clog2(WINDOW_SIZE);

  // Register window: dc00-dcff, aliased onto the low 16 bytes
  localparam logic [7:0]  WIN_PAGE = 8'hdc;
  localparam logic [11:0] WIN_BASE = 12'hdc0;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_KEY   = 2'd3
  } mode_t;

  typedef enum logic [WIN_IDX_W-1:0] {
    OFF_PRA    = 4'h0,
    OFF_PRB    = 4'h1,
    OFF_DDRA   = 4'h2,
    OFF_DDRB   = 4'h3,
    OFF_TA_LO  = 4'h4,
    OFF_TA_HI  = 4'h5,
    OFF_TB_LO  = 4'h6,
    OFF_TB_HI  = 4'h7,
    OFF_TOD_10 = 4'h8,
    OFF_TOD_S  = 4'h9,
    OFF_TOD_M  = 4'ha,
    OFF_TOD_H  = 4'hb,
    OFF_SDR    = 4'hc,
    OFF_ICR    = 4'hd,
    OFF_CRA    = 4'he,
    OFF_CRB    = 4'hf
  } reg_off_t;

  // Control bits
  localparam int CR_START   = 0;
  localparam int CR_LOAD    = 4;
  localparam int ICR_SET    = 7;

  typedef struct packed {
    logic tick;
    logic wr_lo;
    logic wr_hi;
    logic wr_ctrl;
  } timer_ctl_t;

endpackage

// ===== hdl/ciatk_timer.sv =====
`timescale 1ns / 1ps

module ciatk_timer (
  input  logic                  clk,
  input  logic                  rst,
  input  ciatk_pkg::timer_ctl_t ctl,
  input  logic [7:0]            data,
  input  logic [31:0]           elapsed,
  input  logic                  cycle_mode,
  input  logic                  irq_enable,
  output logic [15:0]           count,
  output logic                  irq
);
  import ciatk_pkg::*;

  logic [15:0] reload;
  logic        run;
  logic [15:0] count_next;
  logic [15:0] reload_next;
  logic        run_next;
  logic        underflow;

  assign underflow = ({16'd0, count} <= elapsed);

  always_comb begin
    count_next  = count;
    reload_next = reload;
    run_next    = run;
    irq         = 1'b0;
    if (ctl.tick && run && cycle_mode) begin
      if (underflow) begin
        count_next = reload;
        irq        = irq_enable;
      end else begin
        count_next = count - elapsed[15:0];
      end
    end
    if (ctl.wr_lo) begin
      reload_next[7:0] = data;
    end
    if (ctl.wr_hi) begin
      reload_next[15:8] = data;
    end
    if (ctl.wr_ctrl) begin
      run_next = data[CR_START];
      // stopping drops the latch high byte
      if (!data[CR_START]) begin
        reload_next[15:8] = 8'h00;
      end
      if (data[CR_LOAD]) begin
        count_next = reload_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      reload <= '0;
      run    <= 1'b0;
    end else begin
      count  <= count_next;
      reload <= reload_next;
      run    <= run_next;
    end
  end

endmodule

// ===== hdl/ciatk_keys.sv =====
`timescale 1ns / 1ps

module ciatk_keys (
  input  logic       clk,
  input  logic       rst,
  input  logic       key_event,
  input  logic [5:0] key_code,
  input  logic       key_pressed,
  input  logic [7:0] row_select,
  output logic [7:0] columns
);
  import ciatk_pkg::*;

  logic [KEY_COUNT-1:0] pressed_keys;
  logic [63:0]          matrix;
  logic [7:0]           acc;
  logic                 key_in_range;

  assign key_in_range = ({1'b0, key_code} < 7'(KEY_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_keys <= '0;
    end else if (key_event && key_in_range) begin
      pressed_keys[key_code[KEY_IDX_W-1:0]] <= key_pressed;
    end
  end

  assign matrix = 64'(pressed_keys);

  // A row is driven when its select bit is low; OR the driven rows, active low
  always_comb begin
    acc = 8'h00;
    for (int r = 0; r < 8; r++) begin
      if (!row_select[r]) begin
        acc = acc | matrix[r*8 +: 8];
      end
    end
    columns = ~acc;
  end

endmodule

// ===== hdl/cia_timers_keyboard_port.sv =====
`timescale 1ns / 1ps
// Timer and keyboard-port section of a 6526-style interface adapter.
// Pipeline: an item is held in the input register stage, then in the result register until it transfers.
// Throughput: one item per cycle; the only stall is back-pressure on the result register.
// Reset (rst, synchronous): timers stopped and zeroed, interrupts disabled, all keys released,
// cycle reference and window store cleared, both pipeline stages emptied.
module cia_timers_keyboard_port (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [31:0] cycle_count, [47:32] address, [55:48] data_in, [61:56] key_code,
  // [62] key_pressed, [63] zero
  input  logic [63:0] s_tdata,
  // [1:0] mode
  input  logic [1:0]  s_tuser,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] read_data, [8] irq_timer_a, [9] irq_timer_b, [10] forward_access,
  // [26:11] effective_address, [31:27] zero
  output logic [31:0] m_tdata
);
  import ciatk_pkg::*;

  // Input register stage
  logic        s1_valid;
  mode_t       s1_mode;
  logic [31:0] s1_cycle;
  logic [15:0] s1_address;
  logic [7:0]  s1_data;
  logic [5:0]  s1_key_code;
  logic        s1_key_pressed;

  logic        fire;

  // Block state outside the timers
  logic [31:0] last_cycle;
  logic        source_a;
  logic [1:0]  source_b;
  logic        enable_a;
  logic        enable_b;
  logic [7:0]  window [WINDOW_SIZE];

  // Decode
  logic                 in_window;
  reg_off_t             offset;
  logic                 is_tick;
  logic                 is_key;
  logic                 win_read;
  logic                 win_write;
  logic [31:0]          elapsed;
  timer_ctl_t           ctl_a;
  timer_ctl_t           ctl_b;
  logic [15:0]          count_a;
  logic [15:0]          count_b;
  logic                 irq_a;
  logic                 irq_b;
  logic [7:0]           columns;

  // Result assembly
  logic [7:0]  read_data;
  logic        forward_access;
  logic [15:0] effective_address;

  // Advance the input stage whenever the result register is free or draining
  assign fire     = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_mode        <= mode_t'(s_tuser);
      s1_cycle       <= s_tdata[31:0];
      s1_address     <= s_tdata[47:32];
      s1_data        <= s_tdata[55:48];
      s1_key_code    <= s_tdata[61:56];
      s1_key_pressed <= s_tdata[62];
    end
  end

  assign in_window = (s1_address[15:8] == WIN_PAGE);
  assign offset    = reg_off_t'(s1_address[WIN_IDX_W-1:0]);
  assign is_tick   = fire && (s1_mode == MODE_TICK);
  assign is_key    = fire && (s1_mode == MODE_KEY);
  assign win_read  = (s1_mode == MODE_READ) && in_window;
  assign win_write = fire && (s1_mode == MODE_WRITE) && in_window;
  assign elapsed   = s1_cycle - last_cycle;

  always_comb begin
    ctl_a = '0;
    ctl_b = '0;
    ctl_a.tick    = is_tick;
    ctl_b.tick    = is_tick;
    ctl_a.wr_lo   = win_write && (offset == OFF_TA_LO);
    ctl_a.wr_hi   = win_write && (offset == OFF_TA_HI);
    ctl_a.wr_ctrl = win_write && (offset == OFF_CRA);
    ctl_b.wr_lo   = win_write && (offset == OFF_TB_LO);
    ctl_b.wr_hi   = win_write && (offset == OFF_TB_HI);
    ctl_b.wr_ctrl = win_write && (offset == OFF_CRB);
  end

  ciatk_timer u_timer_a (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_a),
    .data      (s1_data),
    .elapsed   (elapsed),
    .cycle_mode(source_a == 1'b0),
    .irq_enable(enable_a),
    .count     (count_a),
    .irq       (irq_a)
  );

  ciatk_timer u_timer_b (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_b),
    .data      (s1_data),
    .elapsed   (elapsed),
    .cycle_mode(source_b == 2'b00),
    .irq_enable(enable_b),
    .count     (count_b),
    .irq       (irq_b)
  );

  // Port B reads scan the key matrix with port A as the row drive
  ciatk_keys u_keys (
    .clk        (clk),
    .rst        (rst),
    .key_event  (is_key),
    .key_code   (s1_key_code),
    .key_pressed(s1_key_pressed),
    .row_select (window[OFF_PRA]),
    .columns    (columns)
  );

  // Cycle reference moves on every tick, running timers or not
  always_ff @(posedge clk) begin
    if (rst) begin
      last_cycle <= '0;
    end else if (is_tick) begin
      last_cycle <= s1_cycle;
    end
  end

  // Control bits held outside the timers: source selects and interrupt enables
  always_ff @(posedge clk) begin
    if (rst) begin
      source_a <= 1'b0;
      source_b <= 2'b00;
      enable_a <= 1'b0;
      enable_b <= 1'b0;
    end else if (win_write) begin
      if (offset == OFF_CRA) begin
        source_a <= s1_data[5];
      end
      if (offset == OFF_CRB) begin
        source_b <= s1_data[6:5];
      end
      // ICR write only touches the enables when the set bit is high
      if ((offset == OFF_ICR) && s1_data[ICR_SET]) begin
        enable_a <= s1_data[0];
        enable_b <= s1_data[1];
      end
    end
  end

  // Window store: the timer latch bytes bypass it, every other offset lands here
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        window[i] <= 8'h00;
      end
    end else if (win_write) begin
      if (!((offset == OFF_TA_LO) || (offset == OFF_TA_HI) ||
            (offset == OFF_TB_LO) || (offset == OFF_TB_HI))) begin
        window[offset] <= s1_data;
      end
    end
  end

  always_comb begin
    read_data         = 8'h00;
    forward_access    = 1'b0;
    effective_address = 16'h0000;
    if ((s1_mode == MODE_READ) || (s1_mode == MODE_WRITE)) begin
      if (in_window) begin
        effective_address = {WIN_BASE, offset};
      end else begin
        forward_access    = 1'b1;
        effective_address = s1_address;
      end
    end
    if (win_read) begin
      unique case (offset)
        OFF_PRB:   read_data = columns;
        OFF_TA_LO: read_data = count_a[7:0];
        OFF_TA_HI: read_data = count_a[15:8];
        OFF_TB_LO: read_data = count_b[7:0];
        OFF_TB_HI: read_data = count_b[15:8];
        default:   read_data = window[offset];
      endcase
    end
  end

  // Result register: load on each processed item, hold until the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {5'b00000, effective_address, forward_access, irq_b, irq_a, read_data};
    end
  end

endmodule

// ===== tb/sv/ciatk_result_checker.sv =====
`timescale 1ns / 1ps

module ciatk_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  output int unsigned mismatches,
  output int unsigned replies_matched
);
  import ciatk_pkg::*;

  // Same bit order as m_tdata[26:0]
  typedef struct packed {
    logic [15:0] eff_addr;
    logic        fwd;
    logic        irq_b;
    logic        irq_a;
    logic [7:0]  rd_data;
  } cia_reply_t;

  // Shadow copy of the adapter state
  logic [15:0] ta_count, tb_count, ta_latch, tb_latch;
  logic        ta_run, tb_run, ta_irq_en, tb_irq_en;
  logic        ta_src;
  logic [1:0]  tb_src;
  logic [63:0] key_matrix;
  logic [31:0] prev_cycle;
  logic [7:0]  win_store [WINDOW_SIZE];

  cia_reply_t port_replies [$];

  function automatic cia_reply_t cia_step(input mode_t mode, input logic [63:0] d);
    cia_reply_t  r;
    logic [31:0] elapsed;
    logic [15:0] addr;
    logic [7:0]  din;
    logic [7:0]  cols;
    reg_off_t    off;
    r       = '0;
    addr    = d[47:32];
    din     = d[55:48];
    off     = reg_off_t'(addr[3:0]);
    case (mode)
      MODE_TICK: begin
        elapsed = d[31:0] - prev_cycle;
        // Any elapsed span at least as long as the count is one underflow
        if (ta_run && ta_src == 1'b0) begin
          if ({16'd0, ta_count} <= elapsed) begin
            ta_count = ta_latch;
            r.irq_a  = ta_irq_en;
          end else begin
            ta_count = ta_count - elapsed[15:0];
          end
        end
        if (tb_run && tb_src == 2'd0) begin
          if ({16'd0, tb_count} <= elapsed) begin
            tb_count = tb_latch;
            r.irq_b  = tb_irq_en;
          end else begin
            tb_count = tb_count - elapsed[15:0];
          end
        end
        prev_cycle = d[31:0];
      end
      MODE_KEY: begin
        key_matrix[d[61:56]] = d[62];
      end
      default: begin
        if (addr[15:8] != WIN_PAGE) begin
          r.fwd      = 1'b1;
          r.eff_addr = addr;
        end else begin
          r.eff_addr = {WIN_BASE, addr[3:0]};
          if (mode == MODE_READ) begin
            case (off)
              OFF_PRB: begin
                cols = '0;
                for (int row = 0; row < 8; row++)
                  if (!win_store[OFF_PRA][row]) cols |= key_matrix[row*8 +: 8];
                r.rd_data = ~cols;
              end
              OFF_TA_LO: r.rd_data = ta_count[7:0];
              OFF_TA_HI: r.rd_data = ta_count[15:8];
              OFF_TB_LO: r.rd_data = tb_count[7:0];
              OFF_TB_HI: r.rd_data = tb_count[15:8];
              default:   r.rd_data = win_store[off];
            endcase
          end else begin
            case (off)
              OFF_TA_LO: ta_latch[7:0]  = din;
              OFF_TA_HI: ta_latch[15:8] = din;
              OFF_TB_LO: tb_latch[7:0]  = din;
              OFF_TB_HI: tb_latch[15:8] = din;
              OFF_ICR: begin
                if (din[ICR_SET]) begin
                  ta_irq_en = din[0];
                  tb_irq_en = din[1];
                end
                win_store[off] = din;
              end
              OFF_CRA: begin
                ta_run = din[CR_START];
                if (!din[CR_START]) ta_latch[15:8] = 8'h00;
                if (din[CR_LOAD]) ta_count = ta_latch;
                ta_src = din[5];
                win_store[off] = din;
              end
              OFF_CRB: begin
                tb_run = din[CR_START];
                if (!din[CR_START]) tb_latch[15:8] = 8'h00;
                if (din[CR_LOAD]) tb_count = tb_latch;
                tb_src = din[6:5];
                win_store[off] = din;
              end
              default: win_store[off] = din;
            endcase
          end
        end
      end
    endcase
    return r;
  endfunction

  cia_reply_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      ta_count <= '0; tb_count <= '0; ta_latch <= '0; tb_latch <= '0;
      ta_run <= 1'b0; tb_run <= 1'b0; ta_irq_en <= 1'b0; tb_irq_en <= 1'b0;
      ta_src <= 1'b0; tb_src <= '0;
      key_matrix <= '0;
      prev_cycle <= '0;
      for (int i = 0; i < WINDOW_SIZE; i++) win_store[i] <= '0;
      port_replies.delete();
      mismatches      <= 0;
      replies_matched <= 0;
    end else begin
      // Predict before checking so a same-edge input is already queued
      if (s_tvalid && s_tready) port_replies.push_back(cia_step(mode_t'(s_tuser), s_tdata));
      if (m_tvalid && m_tready) begin
        got = cia_reply_t'(m_tdata[26:0]);
        if (port_replies.size() == 0) begin
          $display("%0t: result expected none got %08h", $time, m_tdata);
          mismatches = mismatches + 1;
        end else begin
          want = port_replies.pop_front();
          replies_matched = replies_matched + 1;
          if (got != want) begin
            if (got.rd_data != want.rd_data)
              $display("%0t: read_data expected %02h got %02h", $time,
                       want.rd_data, got.rd_data);
            if (got.irq_a != want.irq_a)
              $display("%0t: irq_timer_a expected %0b got %0b", $time,
                       want.irq_a, got.irq_a);
            if (got.irq_b != want.irq_b)
              $display("%0t: irq_timer_b expected %0b got %0b", $time,
                       want.irq_b, got.irq_b);
            if (got.fwd != want.fwd)
              $display("%0t: forward_access expected %0b got %0b", $time,
                       want.fwd, got.fwd);
            if (got.eff_addr != want.eff_addr)
              $display("%0t: effective_address expected %04h got %04h", $time,
                       want.eff_addr, got.eff_addr);
            mismatches = mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/cia_timers_keyboard_port_tb.sv =====
`timescale 1ns / 1ps

module cia_timers_keyboard_port_tb;
  import ciatk_pkg::*;

  // Generous bound; a correct run finishes well inside it
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_PER_PHASE = 150;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = MODE_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  int unsigned mismatches, replies_matched;
  int unsigned items_sent   = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned snd_idle_pct = 8;
  int unsigned rcv_idle_pct = 61;
  logic [31:0] cyc_now      = '0;

  cia_timers_keyboard_port u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  ciatk_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatches      (mismatches),
    .replies_matched (replies_matched)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at the current rate, one decision per cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Cut the run off if the block hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Address of a register inside the window (page dc, low alias)
  function automatic logic [15:0] win(input reg_off_t off);
    return {WIN_BASE, 4'(off)};
  endfunction

  // Present one item, with random gaps in front of it, and hold until its transfer.
  // tvalid stays high afterwards so back-to-back items go out without dropping it in between.
  task automatic send_item(input mode_t mode, input logic [31:0] cyc, input logic [15:0] addr,
                           input logic [7:0] din, input logic [5:0] key, input logic press);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {1'b0, press, key, din, addr, cyc};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic tick_at(input logic [31:0] cyc);
    send_item(MODE_TICK, cyc, 16'($urandom), 8'($urandom), 6'($urandom), 1'($urandom));
  endtask

  task automatic bus_rd(input logic [15:0] addr);
    send_item(MODE_READ, $urandom, addr, 8'($urandom), 6'($urandom), 1'($urandom));
  endtask

  task automatic bus_wr(input logic [15:0] addr, input logic [7:0] din);
    send_item(MODE_WRITE, $urandom, addr, din, 6'($urandom), 1'($urandom));
  endtask

  task automatic key_evt(input logic [5:0] key, input logic press);
    send_item(MODE_KEY, $urandom, 16'($urandom), 8'($urandom), key, press);
  endtask

  // Drop tvalid and hold off until every result so far has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (items_sent != replies_matched) @(posedge clk);
  endtask

  // One random item. Ticks advance the cycle count in small steps so running
  // timers underflow often; now and then the count jumps anywhere.
  task automatic random_item();
    int unsigned pick;
    reg_off_t    off;
    logic [15:0] addr;
    logic [7:0]  din;
    pick = $urandom_range(99);
    off  = reg_off_t'($urandom_range(15));
    addr = {WIN_PAGE, 4'($urandom_range(15)), 4'(off)};
    din  = 8'($urandom);
    if (pick < 35) begin
      if ($urandom_range(11) == 0) cyc_now = $urandom;
      else cyc_now = cyc_now + $urandom_range(400);
      tick_at(cyc_now);
    end else if (pick < 55) begin
      if ($urandom_range(6) == 0) addr = 16'($urandom);
      bus_rd(addr);
    end else if (pick < 85) begin
      // Keep latches short and timers mostly running in cycle mode
      case (off)
        OFF_TA_HI, OFF_TB_HI: if ($urandom_range(3) != 0) din = 8'($urandom_range(2));
        OFF_CRA, OFF_CRB:     if ($urandom_range(3) != 0) din = (din & 8'h9f) | 8'h01;
        OFF_ICR:              if ($urandom_range(3) != 0) din[ICR_SET] = 1'b1;
        default: ;
      endcase
      if ($urandom_range(6) == 0) addr = 16'($urandom);
      bus_wr(addr, din);
    end else begin
      key_evt(6'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty matrix scan, then keys in the first and last rows
    bus_rd(win(OFF_PRB));
    key_evt(6'h00, 1'b1);
    key_evt(6'h3f, 1'b1);
    bus_rd(win(OFF_PRB));
    // Enable only row 0, so the last-row key drops out of the scan
    bus_wr(win(OFF_PRA), 8'hfe);
    bus_rd(win(OFF_PRB));
    key_evt(6'h00, 1'b0);
    // Timer A: full latch, both interrupts on, start with force-load
    bus_wr(win(OFF_TA_LO), 8'hff);
    bus_wr(win(OFF_TA_HI), 8'hff);
    bus_wr(win(OFF_ICR), 8'h83);
    bus_wr(win(OFF_CRA), 8'h11);
    tick_at(32'd5);
    bus_rd(win(OFF_TA_LO));
    bus_rd(win(OFF_TA_HI));
    // Timer B with zero count underflows on a tick with no elapsed cycles
    bus_wr(win(OFF_CRB), 8'h01);
    tick_at(32'd5);
    // Huge elapsed span is a single underflow; then wrap past zero
    tick_at(32'hffff_ffff);
    tick_at(32'h0000_0003);
    // Outside the window: both ends of the address range and the addresses just around the page
    bus_rd(16'h0000);
    bus_wr(16'hffff, 8'h55);
    bus_rd(16'hdbff);
    bus_wr(16'hdd00, 8'haa);
    // Aliased accesses at the top of the page
    bus_wr(16'hdcf8, 8'h3c);
    bus_rd(16'hdcff);
    // Stop clears the latch high byte; count-slope and cascade modes never count
    bus_wr(win(OFF_CRA), 8'h21);
    bus_wr(win(OFF_CRB), 8'h41);
    tick_at(32'd900);
    bus_wr(win(OFF_ICR), 8'h03);
    bus_wr(win(OFF_CRA), 8'h10);
    cyc_now = 32'd1000;

    // Three idling phases; pause for a full drain between them
    drain();
    for (int unsigned i = 0; i < RANDOM_PER_PHASE; i++) random_item();
    drain();
    snd_idle_pct = 61;
    rcv_idle_pct = 8;
    for (int unsigned i = 0; i < RANDOM_PER_PHASE; i++) random_item();
    drain();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    for (int unsigned i = 0; i < RANDOM_PER_PHASE; i++) random_item();
    drain();

    // Catch anything the block emits late
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ciatk_pkg.sv
hdl/ciatk_timer.sv
hdl/ciatk_keys.sv
hdl/cia_timers_keyboard_port.sv
tb/sv/ciatk_result_checker.sv
tb/sv/cia_timers_keyboard_port_tb.sv
